FILE: rtl/two_opt_tour_local_search_unit_macros.svh
// assertion macros for the two-opt tour search unit
`ifndef TWO_OPT_TOUR_LOCAL_SEARCH_UNIT_MACROS_SVH
`define TWO_OPT_TOUR_LOCAL_SEARCH_UNIT_MACROS_SVH

// same-cycle implication
`define TOLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tols assertion failed");

// next-cycle implication
`define TOLS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tols assertion failed");

`endif

FILE: rtl/tols_pkg.sv
`default_nettype none
package tols_pkg;

  localparam int MAX_CITIES = 16;
  localparam int CITY_W     = 4;
  localparam int CNT_W      = 5;
  localparam int DIST_BITS  = 16;
  localparam int DIST_AW    = 2 * CITY_W;
  localparam int LEN_W      = 22;
  localparam int NB_W       = 11;
  localparam int RND_W      = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] REQ_DIST = 2'd0;
  localparam logic [1:0] REQ_TOUR = 2'd1;
  localparam logic [1:0] REQ_RUN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_NEIGHBORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROUNDS    = 2'd2;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [CITY_W-1:0]    row_index;
    logic [CITY_W-1:0]    col_index;
    logic [DIST_BITS-1:0] edge_length;
  } in_beat_t;

  typedef struct packed {
    logic [CITY_W-1:0] position;
    logic [CITY_W-1:0] city;
    logic [LEN_W-1:0]  tour_length;
    logic              round_limit_hit;
    logic              last;
  } out_beat_t;

endpackage
`default_nettype wire

FILE: rtl/two_opt_tour_local_search_unit.sv
`default_nettype none
// Best-improvement 2-opt search over a tour of up to 16 cities. Load beats (distance entries
// and tour cities) are taken one per cycle while the block is idle. A run beat holds the input
// for the whole search: every candidate (and the starting tour) is scored by walking the closed
// tour through the tour memory and then the distance memory; a reversal is applied one exchanged
// pair at a time (read both ends, then write both); the result tour then leaves one beat at a
// time, each beat read from the tour memory and held until the output is not stalled.
module two_opt_tour_local_search_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire tols_pkg::in_beat_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output tols_pkg::out_beat_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [tols_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tols_pkg::CFG_W-1:0]    cfg_data
);
  import tols_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WALK, ST_RND, ST_SW_RA, ST_SW_RB, ST_SW_WA, ST_SW_WB,
    ST_EM_RD, ST_EM_LD, ST_EM_WT
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]  city_count_r;
  logic [NB_W-1:0]   max_nb_r;
  logic [RND_W-1:0]  max_rounds_r;

  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [RND_W-1:0]  cap_r, cap_nxt, rnd_r, rnd_nxt;
  logic              hit_r, hit_nxt, found_r, found_nxt, base_r, base_nxt;
  logic [CITY_W-1:0] i_r, i_nxt, j_r, j_nxt, bs_r, bs_nxt, be_r, be_nxt;
  logic [NB_W-1:0]   k_r, k_nxt;
  logic [LEN_W-1:0]  cur_r, cur_nxt, best_r, best_nxt, sum_r, sum_nxt;
  logic [CNT_W-1:0]  q_r, q_nxt;
  logic              rd_v_r, rd_v_nxt, first_r, first_nxt, dv_r, dv_nxt;
  logic [CITY_W-1:0] prev_r, prev_nxt, sa_r, sa_nxt, sb_r, sb_nxt, va_r, va_nxt;
  logic [CITY_W-1:0] p_r, p_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_r, out_nxt;

  logic [CITY_W-1:0] tour_mem [MAX_CITIES];
  logic [CITY_W-1:0] tour_rdata_r, tour_raddr, tour_waddr, tour_wdata;
  logic              tour_we;

  logic [DIST_BITS-1:0] dist_rdata;
  logic                 dist_we;

  logic              in_acc, issue, walk_done, better, cand_ok, p_last;
  logic [CITY_W-1:0] posq, ni, nj;
  logic [NB_W-1:0]   k1;
  logic [RND_W-1:0]  rnd1;

  function automatic logic [CITY_W-1:0] map_pos(input logic [CITY_W-1:0] pos,
                                                input logic [CITY_W-1:0] a,
                                                input logic [CITY_W-1:0] b);
    if (pos >= a && pos <= b) return CITY_W'(a + b - pos);
    return pos;
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign dist_we = in_acc && (in_data.req_type == REQ_DIST);

  tols_dist_mem u_dist (
    .clk   (clk),
    .we    (dist_we),
    .waddr ({in_data.row_index, in_data.col_index}),
    .wdata (in_data.edge_length),
    .raddr ({prev_r, tour_rdata_r}),
    .rdata (dist_rdata)
  );

  always_ff @(posedge clk) begin
    if (tour_we) begin
      tour_mem[tour_waddr] <= tour_wdata;
    end
    tour_rdata_r <= tour_mem[tour_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= CNT_W'(MAX_CITIES);
      max_nb_r     <= '1;
      max_rounds_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CITY_COUNT:    city_count_r <= cfg_data[CNT_W-1:0];
        CFG_MAX_NEIGHBORS: max_nb_r     <= cfg_data[NB_W-1:0];
        CFG_MAX_ROUNDS:    max_rounds_r <= cfg_data[RND_W-1:0];
        default: ;
      endcase
    end
  end

  assign posq      = (q_r == n_r) ? '0 : q_r[CITY_W-1:0];
  assign issue     = (q_r <= n_r);
  assign walk_done = !issue && !rd_v_r && !dv_r;
  assign better    = (sum_r < best_r);
  assign k1        = k_r + 1'b1;
  assign rnd1      = rnd_r + 1'b1;
  assign p_last    = ({1'b0, p_r} + 1'b1 == n_r);

  always_comb begin
    if ({1'b0, j_r} + 5'd2 < n_r) begin
      ni = i_r;
      nj = j_r + 1'b1;
    end else begin
      ni = i_r + 1'b1;
      nj = i_r + 4'd2;
    end
    cand_ok = ({1'b0, ni} + 5'd2 < n_r) && (k1 < max_nb_r);
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; cap_nxt = cap_r; rnd_nxt = rnd_r; hit_nxt = hit_r;
    found_nxt = found_r; base_nxt = base_r;
    i_nxt = i_r; j_nxt = j_r; bs_nxt = bs_r; be_nxt = be_r; k_nxt = k_r;
    cur_nxt = cur_r; best_nxt = best_r; sum_nxt = sum_r;
    q_nxt = q_r; rd_v_nxt = 1'b0; first_nxt = first_r; dv_nxt = 1'b0; prev_nxt = prev_r;
    sa_nxt = sa_r; sb_nxt = sb_r; va_nxt = va_r; p_nxt = p_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r;
    tour_raddr = '0;
    tour_we    = 1'b0;
    tour_waddr = in_data.row_index;
    tour_wdata = in_data.col_index;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.req_type == REQ_TOUR) begin
            tour_we = 1'b1;
          end else if (in_data.req_type == REQ_RUN) begin
            if (city_count_r < 5'd4) n_nxt = 5'd4;
            else if (city_count_r > CNT_W'(MAX_CITIES)) n_nxt = CNT_W'(MAX_CITIES);
            else n_nxt = city_count_r;
            cap_nxt   = (max_rounds_r == '0) ? RND_W'(1) : max_rounds_r;
            rnd_nxt   = '0;
            hit_nxt   = 1'b0;
            i_nxt     = '0;
            j_nxt     = '0;
            base_nxt  = 1'b1;
            q_nxt     = '0;
            first_nxt = 1'b1;
            sum_nxt   = '0;
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        tour_raddr = map_pos(posq, i_r, j_r);
        if (issue) begin
          q_nxt    = q_r + 1'b1;
          rd_v_nxt = 1'b1;
        end
        if (rd_v_r) begin
          prev_nxt  = tour_rdata_r;
          first_nxt = 1'b0;
          dv_nxt    = !first_r;
        end
        if (dv_r) sum_nxt = sum_r + LEN_W'(dist_rdata);
        if (walk_done) begin
          q_nxt     = '0;
          first_nxt = 1'b1;
          sum_nxt   = '0;
          base_nxt  = 1'b0;
          if (base_r) begin
            cur_nxt   = sum_r;
            best_nxt  = sum_r;
            found_nxt = 1'b0;
            k_nxt     = '0;
            i_nxt     = 4'd1;
            j_nxt     = 4'd2;
            if (n_r > 5'd3 && max_nb_r != '0) begin
              state_nxt = ST_WALK;
            end else begin
              p_nxt     = '0;
              state_nxt = ST_EM_RD;
            end
          end else begin
            k_nxt = k1;
            if (better) begin
              best_nxt  = sum_r;
              bs_nxt    = i_r;
              be_nxt    = j_r;
              found_nxt = 1'b1;
            end
            i_nxt = ni;
            j_nxt = nj;
            state_nxt = cand_ok ? ST_WALK : ST_RND;
          end
        end
      end
      ST_RND: begin
        if (found_r) begin
          sa_nxt    = bs_r;
          sb_nxt    = be_r;
          state_nxt = ST_SW_RA;
        end else begin
          p_nxt     = '0;
          state_nxt = ST_EM_RD;
        end
      end
      ST_SW_RA: begin
        tour_raddr = sa_r;
        state_nxt  = ST_SW_RB;
      end
      ST_SW_RB: begin
        tour_raddr = sb_r;
        va_nxt     = tour_rdata_r;
        state_nxt  = ST_SW_WA;
      end
      ST_SW_WA: begin
        tour_we    = 1'b1;
        tour_waddr = sa_r;
        tour_wdata = tour_rdata_r;
        state_nxt  = ST_SW_WB;
      end
      ST_SW_WB: begin
        tour_we    = 1'b1;
        tour_waddr = sb_r;
        tour_wdata = va_r;
        sa_nxt     = sa_r + 1'b1;
        sb_nxt     = sb_r - 1'b1;
        if ({1'b0, sa_r} + 5'd1 < {1'b0, sb_r} - 5'd1) begin
          state_nxt = ST_SW_RA;
        end else begin
          cur_nxt = best_r;
          rnd_nxt = rnd1;
          if (rnd1 >= cap_r) begin
            hit_nxt   = 1'b1;
            p_nxt     = '0;
            state_nxt = ST_EM_RD;
          end else begin
            found_nxt = 1'b0;
            k_nxt     = '0;
            i_nxt     = 4'd1;
            j_nxt     = 4'd2;
            if (max_nb_r != '0) begin
              state_nxt = ST_WALK;
            end else begin
              p_nxt     = '0;
              state_nxt = ST_EM_RD;
            end
          end
        end
      end
      ST_EM_RD: begin
        tour_raddr = p_r;
        state_nxt  = ST_EM_LD;
      end
      ST_EM_LD: begin
        out_nxt.position        = p_r;
        out_nxt.city            = tour_rdata_r;
        out_nxt.tour_length     = cur_r;
        out_nxt.round_limit_hit = hit_r;
        out_nxt.last            = p_last;
        out_valid_nxt           = 1'b1;
        state_nxt               = ST_EM_WT;
      end
      ST_EM_WT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (p_last) begin
            state_nxt = ST_IDLE;
          end else begin
            p_nxt     = p_r + 1'b1;
            state_nxt = ST_EM_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      rd_v_r      <= 1'b0;
      dv_r        <= 1'b0;
      first_r     <= 1'b1;
      q_r         <= '0;
      n_r         <= CNT_W'(MAX_CITIES);
      cap_r       <= '0;
      rnd_r       <= '0;
      hit_r       <= 1'b0;
      found_r     <= 1'b0;
      base_r      <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      bs_r        <= '0;
      be_r        <= '0;
      k_r         <= '0;
      cur_r       <= '0;
      best_r      <= '0;
      sum_r       <= '0;
      p_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      rd_v_r      <= rd_v_nxt;
      dv_r        <= dv_nxt;
      first_r     <= first_nxt;
      q_r         <= q_nxt;
      n_r         <= n_nxt;
      cap_r       <= cap_nxt;
      rnd_r       <= rnd_nxt;
      hit_r       <= hit_nxt;
      found_r     <= found_nxt;
      base_r      <= base_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      bs_r        <= bs_nxt;
      be_r        <= be_nxt;
      k_r         <= k_nxt;
      cur_r       <= cur_nxt;
      best_r      <= best_nxt;
      sum_r       <= sum_nxt;
      p_r         <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    sa_r   <= sa_nxt;
    sb_r   <= sb_nxt;
    va_r   <= va_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/tols_dist_mem.sv
`default_nettype none
module tols_dist_mem (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [tols_pkg::DIST_AW-1:0]   waddr,
  input  wire logic [tols_pkg::DIST_BITS-1:0] wdata,
  input  wire logic [tols_pkg::DIST_AW-1:0]   raddr,
  output logic      [tols_pkg::DIST_BITS-1:0] rdata
);
  import tols_pkg::*;

  logic [DIST_BITS-1:0] mem [2**DIST_AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/tols_checker.sv
`default_nettype none
`include "two_opt_tour_local_search_unit_macros.svh"
module tols_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire tols_pkg::in_beat_t            in_data,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire tols_pkg::out_beat_t           out_data
);
  import tols_pkg::*;

  // stalled result beat holds
  `TOLS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // no new input while a result beat is pending
  `TOLS_ASSERT_IMP(a_busy_emit, out_valid, in_stall)
  // a run beat occupies the block
  `TOLS_ASSERT_NXT(a_run_busy, in_valid && !in_stall && in_data.req_type == REQ_RUN, in_stall)

endmodule

bind two_opt_tour_local_search_unit tols_checker u_tols_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
